[rtl/csle_pkg.sv]
package csle_pkg;

	localparam int unsigned MaxChars = 5;
	localparam int unsigned LenW = 3;

	localparam logic [7:0] ChDquote = 8'h22;
	localparam logic [7:0] ChSquote = 8'h27;
	localparam logic [7:0] ChQmark = 8'h3F;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChLowX = 8'h78;
	localparam logic [7:0] ChNone = 8'h00;

	localparam logic KindData = 1'b0;
	localparam logic KindEnd = 1'b1;

	typedef struct packed {
		logic [MaxChars-1:0][7:0] chars;
		logic [LenW-1:0] len;
	} csle_desc_t;

	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			ChSquote: r = ChSquote;
			ChDquote: r = ChDquote;
			ChQmark: r = ChQmark;
			ChBslash: r = ChBslash;
			8'h07: r = 8'h61;
			8'h08: r = 8'h62;
			8'h0C: r = 8'h66;
			8'h0A: r = 8'h6E;
			8'h0D: r = 8'h72;
			8'h09: r = 8'h74;
			8'h0B: r = 8'h76;
			default: r = ChNone;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h57 + {4'd0, n};
		end
		return r;
	endfunction

endpackage

[rtl/csle_front.sv]
module csle_front
	import csle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic kind,
	input logic [7:0] data_byte,
	output csle_desc_t desc
);

	logic quote_open_q;
	logic [3:0][7:0] body;
	logic [LenW-1:0] body_len;
	logic [7:0] letter;
	logic lead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_open_q <= 1'b0;
		end else if (take) begin
			quote_open_q <= (kind == KindData);
		end
	end

	always_comb begin
		letter = escape_letter(data_byte);
		body = '0;
		body_len = '0;
		lead = !quote_open_q;
		if (kind == KindEnd) begin
			body[0] = ChDquote;
			body_len = LenW'(1);
		end else if (letter != ChNone) begin
			body[0] = ChBslash;
			body[1] = letter;
			body_len = LenW'(2);
		end else if (data_byte >= 8'h20 && data_byte <= 8'h7E) begin
			body[0] = data_byte;
			body_len = LenW'(1);
		end else begin
			body[0] = ChBslash;
			body[1] = ChLowX;
			body[2] = hex_digit(data_byte[7:4]);
			body[3] = hex_digit(data_byte[3:0]);
			body_len = LenW'(4);
		end
		desc.chars = '0;
		if (lead) begin
			desc.chars[0] = ChDquote;
			for (int i = 1; i < MaxChars; i++) begin
				desc.chars[i] = body[i-1];
			end
			desc.len = body_len + LenW'(1);
		end else begin
			for (int i = 0; i < MaxChars - 1; i++) begin
				desc.chars[i] = body[i];
			end
			desc.len = body_len;
		end
	end

endmodule

[rtl/csle_fifo.sv]
module csle_fifo
	import csle_pkg::*;
#(
	parameter int unsigned Depth = 4
)
(
	input logic clk,
	input logic arst_n,
	input logic wr,
	input csle_desc_t wr_data,
	output logic full,
	input logic rd,
	output csle_desc_t rd_data,
	output logic empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	csle_desc_t mem [Depth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_data = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

[rtl/csle_back.sv]
module csle_back
	import csle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input csle_desc_t desc,
	input logic desc_empty,
	output logic desc_take,
	output logic [7:0] out_char,
	output logic last,
	output logic empty,
	input logic pop
);

	logic [LenW-1:0] idx_q;
	logic [7:0] char_q;
	logic last_q;
	logic valid_q;
	logic load;
	logic at_end;

	assign load = !desc_empty && (!valid_q || pop);
	assign at_end = (idx_q == desc.len - LenW'(1));
	assign desc_take = load && at_end;

	assign out_char = char_q;
	assign last = last_q;
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= at_end ? '0 : idx_q + LenW'(1);
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= desc.chars[idx_q];
			last_q <= at_end;
		end
	end

endmodule

[rtl/c_string_literal_escaper_top.sv]
// an item gives one to five output bytes (four for a hex escape, five with an opening quote)
// the first byte of a transaction's output passes the descriptor queue, then the result register
// throughput: one byte per cycle, set by the single-byte result register, while pop is high and
// the queue is not empty; the descriptor queue lets the input side run ahead by FifoDepth items
// reset: asynchronous, clears quote state, queue pointers and output valid
module c_string_literal_escaper_top
	import csle_pkg::*;
#(
	parameter int unsigned FifoDepth = 4
)
(
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic kind,
	input logic [7:0] data_byte,
	output logic empty,
	input logic pop,
	output logic [7:0] out_char,
	output logic last
);

	csle_desc_t front_desc;
	csle_desc_t queue_desc;
	logic queue_empty;
	logic queue_take;
	logic take;

	assign take = push && !full;

	csle_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.kind(kind),
		.data_byte(data_byte),
		.desc(front_desc)
	);

	csle_fifo #(
		.Depth(FifoDepth)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(push),
		.wr_data(front_desc),
		.full(full),
		.rd(queue_take),
		.rd_data(queue_desc),
		.empty(queue_empty)
	);

	csle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.desc(queue_desc),
		.desc_empty(queue_empty),
		.desc_take(queue_take),
		.out_char(out_char),
		.last(last),
		.empty(empty),
		.pop(pop)
	);

endmodule
